/* sv/ufr_pkg.sv */
// ----------------------------------------------------------------------------
// ufr_pkg: shared types and constants for the UART frame receiver
// Word codes, status codes, register indexes and the structs that pass
// between the front end, the frame engine and the touch event queue.
// ----------------------------------------------------------------------------
package ufr_pkg;

  // Touch event queue depth, frame length bounds and shortest touch frame
  localparam int QUEUE_DEPTH  = 16;
  localparam int FRAME_MAX    = 64;
  localparam int FRAME_MIN    = 6;
  localparam int TOUCH_MINLEN = 12;

  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int QIDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FCNT_W = 7;
  localparam int FPOS_W = 6;
  localparam int KEY_W  = 32;
  localparam int VAL_W  = 16;

  // Frame byte positions
  localparam int POS_CMD     = 1;
  localparam int POS_KEY_LO  = 2;
  localparam int POS_KEY_HI  = 5;
  localparam int POS_VAL_LO  = 6;
  localparam int POS_VAL_HI  = 7;
  localparam int TAIL_BYTES  = 4;

  // Register reset values
  localparam logic [7:0]        HEADER_RST = 8'hAA;
  localparam logic [31:0]       TAIL_RST   = 32'hCC33C33C;
  localparam logic [FCNT_W-1:0] LIMIT_RST  = FCNT_W'(FRAME_MAX);

  typedef enum logic [1:0] {
    OP_BYTE  = 2'd0,
    OP_TAKE  = 2'd1,
    OP_ABORT = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    ST_SKIPPED    = 4'd0,
    ST_STORED     = 4'd1,
    ST_FRAME_DONE = 4'd2,
    ST_TOUCH      = 4'd3,
    ST_UNEXPECTED = 4'd4,
    ST_OVERSIZE   = 4'd5,
    ST_HIT        = 4'd6,
    ST_MISS       = 4'd7,
    ST_ABORTED    = 4'd8
  } status_e;

  typedef enum logic [2:0] {
    CFG_HEADER   = 3'd0,
    CFG_TAIL     = 3'd1,
    CFG_TOUCH    = 3'd2,
    CFG_EXPECTED = 3'd3,
    CFG_LIMIT    = 3'd4
  } cfg_idx_e;

  // Classified word, front to back
  typedef struct packed {
    op_e              op;
    logic [7:0]       rx_byte;
    logic [KEY_W-1:0] lookup_key;
  } work_t;

  // Frame engine to event queue
  typedef struct packed {
    logic             push;
    logic             take;
    logic [KEY_W-1:0] push_key;
    logic [VAL_W-1:0] push_value;
    logic [KEY_W-1:0] lookup_key;
  } evq_req_t;

  // Event queue answer for the word in flight
  typedef struct packed {
    logic              hit;
    logic [VAL_W-1:0]  taken_value;
    logic [QCNT_W-1:0] count;
    logic              dropped;
  } evq_rsp_t;

endpackage

/* sv/ufr_front.sv */
// ----------------------------------------------------------------------------
// ufr_front: input decode and work queue
// Accepts input words, classifies the action code and holds them in a
// two-entry queue until the frame engine pulls them.
// ----------------------------------------------------------------------------
module ufr_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        action_i,
  input  logic [7:0]        rx_byte_i,
  input  logic [31:0]       lookup_key_i,
  output logic              work_valid_o,
  output ufr_pkg::work_t    work_o,
  input  logic              work_pop_i
);

  ufr_pkg::work_t slot_q [2];
  logic           wr_ptr_q, wr_ptr_d;
  logic           rd_ptr_q, rd_ptr_d;
  logic [1:0]     cnt_q, cnt_d;
  logic           push, pop;
  ufr_pkg::work_t cls;

  always_comb begin
    cls.rx_byte    = rx_byte_i;
    cls.lookup_key = lookup_key_i;
    unique case (action_i)
      ufr_pkg::OP_BYTE:  cls.op = ufr_pkg::OP_BYTE;
      ufr_pkg::OP_TAKE:  cls.op = ufr_pkg::OP_TAKE;
      ufr_pkg::OP_ABORT: cls.op = ufr_pkg::OP_ABORT;
      default:           cls.op = ufr_pkg::OP_NONE;
    endcase
  end

  assign in_stall_o   = (cnt_q == 2'd2);
  assign push         = in_valid_i && !in_stall_o;
  assign work_valid_o = (cnt_q != 2'd0);
  assign pop          = work_pop_i && work_valid_o;
  assign work_o       = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push;
    rd_ptr_d = rd_ptr_q ^ pop;
    cnt_d    = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= cls;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3)
    else $error("work queue count out of range");

  a_ptr_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd0 || cnt_q == 2'd2) |-> wr_ptr_q == rd_ptr_q)
    else $error("work queue pointers disagree with count");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    work_pop_i |-> work_valid_o)
    else $error("work queue popped while empty");

endmodule

/* sv/ufr_evq.sv */
// ----------------------------------------------------------------------------
// ufr_evq: keyed touch event queue
// Shift-register FIFO of key/value pairs. Push drops the oldest entry when
// full; take removes the first entry with a matching key and closes the gap.
// ----------------------------------------------------------------------------
module ufr_evq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  ufr_pkg::evq_req_t   req_i,
  output ufr_pkg::evq_rsp_t   rsp_o
);

  localparam int D = ufr_pkg::QUEUE_DEPTH;

  logic [ufr_pkg::KEY_W-1:0]  key_q [D];
  logic [ufr_pkg::VAL_W-1:0]  val_q [D];
  logic [ufr_pkg::QCNT_W-1:0] total_q, total_d;

  logic [D-1:0] match, first, below;
  logic         full, do_push, do_take, hit;
  logic [ufr_pkg::VAL_W-1:0] tval;

  assign full    = (total_q == ufr_pkg::QCNT_W'(D));
  assign do_push = en_i && req_i.push && (req_i.push_key != '0);
  assign do_take = en_i && req_i.take;

  // Only live entries take part in the search
  always_comb begin
    for (int i = 0; i < D; i++) begin
      match[i] = (ufr_pkg::QCNT_W'(i) < total_q) && (key_q[i] == req_i.lookup_key);
    end
  end

  // Lowest match, and the entries in front of it that stay put
  assign first = match & ~(match - D'(1));
  assign below = (match ^ (match - D'(1))) & ~first;
  assign hit   = (match != '0);

  always_comb begin
    tval = '0;
    for (int i = 0; i < D; i++) begin
      tval = tval | (first[i] ? val_q[i] : '0);
    end
  end

  always_comb begin
    total_d = total_q;
    if (do_push && !full) begin
      total_d = total_q + ufr_pkg::QCNT_W'(1);
    end else if (do_take && hit) begin
      total_d = total_q - ufr_pkg::QCNT_W'(1);
    end
  end

  always_comb begin
    rsp_o.hit         = req_i.take && hit;
    rsp_o.taken_value = (req_i.take && hit) ? tval : '0;
    rsp_o.count       = total_d;
    rsp_o.dropped     = req_i.push && (req_i.push_key != '0) && full;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0;
    end else begin
      total_q <= total_d;
    end
  end

  for (genvar j = 0; j < D; j++) begin : g_entry
    logic take_shift, push_here, push_shift;
    assign push_here  = do_push && (full ? (j == D - 1)
                                         : (total_q == ufr_pkg::QCNT_W'(j)));
    assign push_shift = do_push && full && (j < D - 1);
    assign take_shift = do_take && hit && !below[j] && (j < D - 1);

    if (j < D - 1) begin : g_mid
      always_ff @(posedge clk_i) begin
        if (push_here) begin
          key_q[j] <= req_i.push_key;
          val_q[j] <= req_i.push_value;
        end else if (push_shift || take_shift) begin
          key_q[j] <= key_q[j+1];
          val_q[j] <= val_q[j+1];
        end
      end
    end else begin : g_last
      always_ff @(posedge clk_i) begin
        if (push_here) begin
          key_q[j] <= req_i.push_key;
          val_q[j] <= req_i.push_value;
        end
      end
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= ufr_pkg::QCNT_W'(D))
    else $error("event count above depth");

  a_drop_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en_i && rsp_o.dropped) |=> total_q == ufr_pkg::QCNT_W'(D))
    else $error("oldest dropped but queue not left full");

  a_take_shrink: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_take && hit) |=> total_q == $past(total_q) - ufr_pkg::QCNT_W'(1))
    else $error("take hit did not remove one entry");

endmodule

/* sv/ufr_back.sv */
// ----------------------------------------------------------------------------
// ufr_back: frame engine and result register
// Pulls classified words, runs the header/tail deframer, drives the touch
// event queue and registers one result word per input word.
// ----------------------------------------------------------------------------
module ufr_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_index_i,
  input  logic [31:0]         cfg_wdata_i,
  input  logic                work_valid_i,
  input  ufr_pkg::work_t      work_i,
  output logic                work_pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [3:0]          status_o,
  output logic [7:0]          frame_byte_o,
  output logic [5:0]          byte_position_o,
  output logic [6:0]          frame_length_o,
  output logic [7:0]          frame_command_o,
  output logic [31:0]         event_key_o,
  output logic [15:0]         event_value_o,
  output logic [15:0]         taken_value_o,
  output logic [4:0]          queue_count_o,
  output logic                oldest_dropped_o
);

  localparam int CW = ufr_pkg::FCNT_W;

  // Configuration
  logic [7:0]    hdr_q, touch_q, expect_q;
  logic [31:0]   tail_q;
  logic [CW-1:0] limit_q;

  // Frame state
  logic          framing_q, framing_d;
  logic [CW-1:0] count_q, count_d;
  logic [7:0]    cmd_q, cmd_d;
  logic [31:0]   key_q, key_d;
  logic [15:0]   val_q, val_d;
  logic [31:0]   last4_q, last4_d;

  // Result register
  logic                  ovalid_q;
  ufr_pkg::status_e      status_q, status_d;
  logic [7:0]            fbyte_q, fbyte_d;
  logic [5:0]            fpos_q, fpos_d;
  logic [CW-1:0]         flen_q, flen_d;
  logic [31:0]           ekey_q, ekey_d;
  logic [15:0]           eval_q, eval_d;
  logic [15:0]           tval_q;
  logic [4:0]            qcnt_q;
  logic                  drop_q;

  logic                  pop;
  logic [CW-1:0]         limit, pos, cnt_inc;
  logic [7:0]            b;
  ufr_pkg::evq_req_t     evq_req;
  ufr_pkg::evq_rsp_t     evq_rsp;

  assign pop        = work_valid_i && (!ovalid_q || !out_stall_i);
  assign work_pop_o = pop;
  assign b          = work_i.rx_byte;

  always_comb begin
    if (limit_q < CW'(ufr_pkg::FRAME_MIN)) begin
      limit = CW'(ufr_pkg::FRAME_MIN);
    end else if (limit_q > CW'(ufr_pkg::FRAME_MAX)) begin
      limit = CW'(ufr_pkg::FRAME_MAX);
    end else begin
      limit = limit_q;
    end
  end

  assign pos     = count_q;
  assign cnt_inc = count_q + CW'(1);

  always_comb begin
    framing_d  = framing_q;
    count_d    = count_q;
    cmd_d      = cmd_q;
    key_d      = key_q;
    val_d      = val_q;
    last4_d    = last4_q;
    status_d   = ufr_pkg::ST_SKIPPED;
    fbyte_d    = '0;
    fpos_d     = '0;
    flen_d     = '0;
    ekey_d     = '0;
    eval_d     = '0;
    evq_req.push       = 1'b0;
    evq_req.take       = 1'b0;
    evq_req.push_key   = key_q;
    evq_req.push_value = val_q;
    evq_req.lookup_key = work_i.lookup_key;

    unique case (work_i.op)
      ufr_pkg::OP_BYTE: begin
        if (!framing_q || count_q >= limit) begin
          if (framing_q) begin
            // Length limit hit: drop, but a header byte opens a new frame
            status_d  = ufr_pkg::ST_OVERSIZE;
            flen_d    = count_q;
            framing_d = 1'b0;
            count_d   = '0;
          end
          if (b == hdr_q) begin
            framing_d = 1'b1;
            count_d   = CW'(1);
            cmd_d     = '0;
            key_d     = '0;
            val_d     = '0;
            last4_d   = {24'd0, b};
            fbyte_d   = b;
            if (!framing_q) begin
              status_d = ufr_pkg::ST_STORED;
            end
          end
        end else begin
          fbyte_d  = b;
          fpos_d   = pos[5:0];
          status_d = ufr_pkg::ST_STORED;
          if (pos == CW'(ufr_pkg::POS_CMD)) begin
            cmd_d = b;
          end else if (pos >= CW'(ufr_pkg::POS_KEY_LO) && pos <= CW'(ufr_pkg::POS_KEY_HI)) begin
            key_d = {key_q[23:0], b};
          end else if (pos == CW'(ufr_pkg::POS_VAL_LO) || pos == CW'(ufr_pkg::POS_VAL_HI)) begin
            val_d = {val_q[7:0], b};
          end
          last4_d = {last4_q[23:0], b};
          count_d = cnt_inc;
          if (cnt_inc >= CW'(ufr_pkg::TAIL_BYTES) && last4_d == tail_q) begin
            flen_d    = cnt_inc;
            framing_d = 1'b0;
            count_d   = '0;
            if (expect_q == '0 || cmd_d == expect_q) begin
              status_d = ufr_pkg::ST_FRAME_DONE;
            end else if (cnt_inc >= CW'(ufr_pkg::TOUCH_MINLEN) && cmd_d == touch_q) begin
              status_d           = ufr_pkg::ST_TOUCH;
              ekey_d             = key_d;
              eval_d             = val_d;
              evq_req.push       = 1'b1;
              evq_req.push_key   = key_d;
              evq_req.push_value = val_d;
            end else begin
              status_d = ufr_pkg::ST_UNEXPECTED;
            end
          end
        end
      end
      ufr_pkg::OP_TAKE: begin
        evq_req.take = 1'b1;
        status_d     = evq_rsp.hit ? ufr_pkg::ST_HIT : ufr_pkg::ST_MISS;
      end
      ufr_pkg::OP_ABORT: begin
        status_d  = ufr_pkg::ST_ABORTED;
        flen_d    = framing_q ? count_q : '0;
        framing_d = 1'b0;
        count_d   = '0;
      end
      default: begin
        status_d = ufr_pkg::ST_SKIPPED;
      end
    endcase
  end

  ufr_evq u_evq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (pop),
    .req_i  (evq_req),
    .rsp_o  (evq_rsp)
  );

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_q    <= ufr_pkg::HEADER_RST;
      tail_q   <= ufr_pkg::TAIL_RST;
      touch_q  <= '0;
      expect_q <= '0;
      limit_q  <= ufr_pkg::LIMIT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        ufr_pkg::CFG_HEADER:   hdr_q    <= cfg_wdata_i[7:0];
        ufr_pkg::CFG_TAIL:     tail_q   <= cfg_wdata_i;
        ufr_pkg::CFG_TOUCH:    touch_q  <= cfg_wdata_i[7:0];
        ufr_pkg::CFG_EXPECTED: expect_q <= cfg_wdata_i[7:0];
        ufr_pkg::CFG_LIMIT:    limit_q  <= cfg_wdata_i[CW-1:0];
        default: ;
      endcase
    end
  end

  // Frame state and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      framing_q <= 1'b0;
      count_q   <= '0;
      cmd_q     <= '0;
      key_q     <= '0;
      val_q     <= '0;
      last4_q   <= '0;
      ovalid_q  <= 1'b0;
    end else begin
      if (pop) begin
        framing_q <= framing_d;
        count_q   <= count_d;
        cmd_q     <= cmd_d;
        key_q     <= key_d;
        val_q     <= val_d;
        last4_q   <= last4_d;
        ovalid_q  <= 1'b1;
      end else if (!out_stall_i) begin
        ovalid_q  <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (pop) begin
      status_q <= status_d;
      fbyte_q  <= fbyte_d;
      fpos_q   <= fpos_d;
      flen_q   <= flen_d;
      ekey_q   <= ekey_d;
      eval_q   <= eval_d;
      tval_q   <= evq_rsp.taken_value;
      qcnt_q   <= 5'(evq_rsp.count);
      drop_q   <= evq_rsp.dropped && evq_req.push;
    end
  end

  assign out_valid_o      = ovalid_q;
  assign status_o         = status_q;
  assign frame_byte_o     = fbyte_q;
  assign byte_position_o  = fpos_q;
  assign frame_length_o   = flen_q;
  assign frame_command_o  = cmd_q;
  assign event_key_o      = ekey_q;
  assign event_value_o    = eval_q;
  assign taken_value_o    = tval_q;
  assign queue_count_o    = qcnt_q;
  assign oldest_dropped_o = drop_q;

  a_count_framing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    framing_q == (count_q != '0))
    else $error("frame count and framing flag disagree");

  a_count_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(ufr_pkg::FRAME_MAX))
    else $error("frame count above frame maximum");

  a_result_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && out_stall_i) |=> ovalid_q && $stable(status_q))
    else $error("stalled result word changed");

endmodule

/* sv/uart_frame_receiver_with_touch_queue.sv */
// ----------------------------------------------------------------------------
// uart_frame_receiver_with_touch_queue: display-link byte deframer
// Header/tail deframer for a serial display link with a keyed touch event
// queue; one result word for every input word.
// ----------------------------------------------------------------------------
// One input word gives exactly one result word. Action 0 feeds a received
// byte: bytes are skipped until the header byte, then stored with their
// position until the last four match the tail word; the completed frame is
// reported as done, queued as a touch event, or dropped as unexpected, and a
// frame that reaches the length limit is dropped as oversize. Action 1 takes
// the first queued touch event with a matching key; action 2 aborts a partial
// frame. The front end latches an accepted word into a two-entry work queue,
// and the frame engine retires one word per cycle while the output is not
// stalled, including the 16-way parallel key search and shift of a take.
// With no stalls a new word can be accepted at every edge; its result passes
// through the work queue slot and then the result register. While a result
// waits on a stalled output the work queue takes up to two more words, then
// the input stalls until the result is taken. Configuration registers
// (header, tail, touch command, expected command, frame limit) are to be
// written through the plain write port only while the block is idle; the
// block itself does not enforce this. There is no clearing pass after reset.
// ----------------------------------------------------------------------------
module uart_frame_receiver_with_touch_queue (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_wdata_i,
  // input words
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  action_i,
  input  logic [7:0]  rx_byte_i,
  input  logic [31:0] lookup_key_i,
  // result words
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  status_o,
  output logic [7:0]  frame_byte_o,
  output logic [5:0]  byte_position_o,
  output logic [6:0]  frame_length_o,
  output logic [7:0]  frame_command_o,
  output logic [31:0] event_key_o,
  output logic [15:0] event_value_o,
  output logic [15:0] taken_value_o,
  output logic [4:0]  queue_count_o,
  output logic        oldest_dropped_o
);

  ufr_pkg::work_t work;
  logic           work_valid;
  logic           work_pop;

  // Front end: decode and buffer
  ufr_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .action_i     (action_i),
    .rx_byte_i    (rx_byte_i),
    .lookup_key_i (lookup_key_i),
    .work_valid_o (work_valid),
    .work_o       (work),
    .work_pop_i   (work_pop)
  );

  // Back end: deframer, event queue, result register
  ufr_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .work_valid_i     (work_valid),
    .work_i           (work),
    .work_pop_o       (work_pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .status_o         (status_o),
    .frame_byte_o     (frame_byte_o),
    .byte_position_o  (byte_position_o),
    .frame_length_o   (frame_length_o),
    .frame_command_o  (frame_command_o),
    .event_key_o      (event_key_o),
    .event_value_o    (event_value_o),
    .taken_value_o    (taken_value_o),
    .queue_count_o    (queue_count_o),
    .oldest_dropped_o (oldest_dropped_o)
  );

endmodule
